### src/pme_pkg.sv
`default_nettype none
package pme_pkg;

  // Fixed sizes of the region and of the result fields.
  localparam int MAX_LEN   = 4096;
  localparam int FRAC_BITS = 4;
  localparam int IDX_W     = 12;
  localparam int CNT_W     = 13;
  localparam int S0_W      = 28;
  localparam int S1_W      = 41;
  localparam int S2_W      = 53;
  localparam int ACC_W     = 56;
  localparam int NUM_W     = 46;
  localparam int DVD_W     = 60;
  localparam int DVS_W     = 28;
  localparam int SQ_W      = 32;
  localparam int ROOT_W    = 16;
  localparam int AVG_W     = 21;

  localparam logic signed [15:0] PEAK_FLOOR_RST = -16'sd15984;
  localparam logic [AVG_W-1:0]   AVG_MAX        = {AVG_W{1'b1}};

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_Q   = 2'd1;
  localparam logic [1:0] ST_NEG_RMS  = 2'd2;

  // Command to the shared divide and square root unit.
  typedef struct packed {
    logic             go;
    logic             is_sqrt;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } ds_cmd_t;

  // Answer from the shared unit; done pulses for one cycle.
  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] value;
  } ds_rsp_t;

endpackage
`default_nettype wire

### src/pme_divsqrt.sv
`default_nettype none
module pme_divsqrt
  import pme_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  input  wire ds_cmd_t cmd,
  output ds_rsp_t      rsp
);

  localparam int SUB_W = DVS_W + 2;
  localparam int CNT_DW = $clog2(DVD_W + 1);

  logic [DVS_W:0]    rem_r, rem_nxt;
  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [CNT_DW-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              sqrt_r, sqrt_nxt;
  logic              done_r, done_nxt;

  logic [SUB_W-1:0]  sub_a, sub_b, diff;
  logic [DVS_W:0]    shifted;

  // One subtractor serves both the restoring divide and the square root.
  always_comb begin
    if (sqrt_r) begin
      shifted = {rem_r[DVS_W-2:0], quo_r[SQ_W-1 -: 2]};
      sub_a   = {1'b0, shifted};
      sub_b   = SUB_W'({root_r, 2'b01});
    end else begin
      shifted = {rem_r[DVS_W-1:0], quo_r[DVD_W-1]};
      sub_a   = {1'b0, shifted};
      sub_b   = {2'b00, dvs_r};
    end
    diff = sub_a - sub_b;
  end

  // Step sequencer: one quotient bit or one root bit per cycle.
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    root_nxt = root_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    sqrt_nxt = sqrt_r;
    done_nxt = 1'b0;
    if (cmd.go) begin
      busy_nxt = 1'b1;
      sqrt_nxt = cmd.is_sqrt;
      rem_nxt  = '0;
      root_nxt = '0;
      quo_nxt  = cmd.dividend;
      dvs_nxt  = cmd.divisor;
      cnt_nxt  = cmd.is_sqrt ? CNT_DW'(ROOT_W) : CNT_DW'(DVD_W);
    end else if (busy_r) begin
      if (!diff[SUB_W-1]) begin
        rem_nxt = diff[DVS_W:0];
      end else begin
        rem_nxt = shifted;
      end
      if (sqrt_r) begin
        quo_nxt  = {quo_r[DVD_W-3:0], 2'b00};
        root_nxt = {root_r[ROOT_W-2:0], ~diff[SUB_W-1]};
      end else begin
        quo_nxt = {quo_r[DVD_W-2:0], ~diff[SUB_W-1]};
      end
      cnt_nxt = cnt_r - CNT_DW'(1);
      if (cnt_r == CNT_DW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      sqrt_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      sqrt_r <= sqrt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    root_r <= root_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.value = sqrt_r ? DVD_W'(root_r) : quo_r;

endmodule
`default_nettype wire

### src/pulse_moment_extractor_core.sv
`default_nettype none
// Pulse moment extractor. Samples of one region stream in over a valid/ready
// channel, and a sample is finished before the next is taken: the one shared
// multiplier forms i*q and then i*i*q as the three moment sums are updated. On
// the sample marked last the block computes the weighted mean and the RMS
// spread about the peak: four more multiplier steps and an add, two restoring
// divides and a square root in one shared bit-serial unit, and no new sample
// is taken until the result is loaded. A finished result sits in an output
// register, so the next region may start while it waits to be taken. A write
// to the peak floor applies from the next region start.
module pulse_moment_extractor_core
  import pme_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_wr_en,
  input  wire signed [15:0] cfg_wr_data,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire signed [15:0] in_sample,
  input  wire        [15:0] in_start_tick,
  input  wire               in_first,
  input  wire               in_last,
  output logic              out_valid,
  input  wire               out_ready,
  output logic signed [27:0] out_q_total,
  output logic signed [15:0] out_q_peak,
  output logic        [16:0] out_peak_tick,
  output logic        [20:0] out_mean_tick,
  output logic        [15:0] out_spread_tick,
  output logic        [15:0] out_region_start,
  output logic        [16:0] out_region_end,
  output logic        [12:0] out_region_size,
  output logic        [1:0]  out_status
);

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_MUL_A    = 16'h0002,
    S_MUL_B    = 16'h0004,
    S_ACC      = 16'h0008,
    S_F_SS     = 16'h0010,
    S_F_PS1    = 16'h0020,
    S_F_PS0    = 16'h0040,
    S_F_PP     = 16'h0080,
    S_F_MSUM   = 16'h0100,
    S_AVG_GO   = 16'h0200,
    S_AVG_WAIT = 16'h0400,
    S_M_GO     = 16'h0800,
    S_M_WAIT   = 16'h1000,
    S_SQ_GO    = 16'h2000,
    S_SQ_WAIT  = 16'h4000,
    S_OUT      = 16'h8000
  } state_t;

  state_t                   state_r, state_nxt;
  logic signed [15:0]       floor_r, floor_nxt;
  logic signed [15:0]       sample_r, sample_nxt;
  logic                     last_r, last_nxt;
  logic                     en_r, en_nxt;
  logic signed [S0_W-1:0]   s0_r, s0_nxt;
  logic signed [S1_W-1:0]   s1_r, s1_nxt;
  logic signed [S2_W-1:0]   s2_r, s2_nxt;
  logic signed [15:0]       peak_r, peak_nxt;
  logic [IDX_W-1:0]         pidx_r, pidx_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [15:0]              start_r, start_nxt;
  logic signed [ACC_W-1:0]  prod_r, prod_nxt;
  logic signed [NUM_W-1:0]  num_r, num_nxt;
  logic signed [ACC_W-1:0]  m_r, m_nxt;
  logic [AVG_W-1:0]         avg_r, avg_nxt;
  logic [ROOT_W-1:0]        rms_r, rms_nxt;
  logic [1:0]               stat_r, stat_nxt;
  logic [SQ_W-1:0]          sqop_r, sqop_nxt;

  logic                     ov_r, ov_nxt;
  logic signed [27:0]       o_qt_r, o_qt_nxt;
  logic signed [15:0]       o_qp_r, o_qp_nxt;
  logic [16:0]              o_tp_r, o_tp_nxt;
  logic [20:0]              o_ta_r, o_ta_nxt;
  logic [15:0]              o_tr_r, o_tr_nxt;
  logic [15:0]              o_rs_r, o_rs_nxt;
  logic [16:0]              o_re_r, o_re_nxt;
  logic [12:0]              o_sz_r, o_sz_nxt;
  logic [1:0]               o_st_r, o_st_nxt;

  logic [15:0]              mul_a;
  logic signed [ACC_W-1:0]  mul_b;
  logic signed [ACC_W+16:0] mul_full;
  logic [16:0]              end_tick;
  logic                     s0_zero, num_bad, m_bad;
  logic [NUM_W-2:0]         num_mag;
  logic [ACC_W-1:0]         m_mag;
  logic [DVS_W-1:0]         s0_mag;
  ds_cmd_t                  ds_cmd;
  ds_rsp_t                  ds_rsp;

  pme_divsqrt u_divsqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (ds_cmd),
    .rsp   (ds_rsp)
  );

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MUL_A: begin
        mul_a = 16'(cnt_r[IDX_W-1:0]);
        mul_b = ACC_W'(sample_r);
      end
      S_MUL_B: begin
        mul_a = 16'(cnt_r[IDX_W-1:0]);
        mul_b = prod_r;
      end
      S_F_SS: begin
        mul_a = start_r;
        mul_b = ACC_W'(s0_r);
      end
      S_F_PS1: begin
        mul_a = 16'(pidx_r);
        mul_b = ACC_W'(s1_r);
      end
      S_F_PS0: begin
        mul_a = 16'(pidx_r);
        mul_b = ACC_W'(s0_r);
      end
      S_F_PP: begin
        mul_a = 16'(pidx_r);
        mul_b = prod_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_full = $signed({1'b0, mul_a}) * mul_b;
  end

  // Sign checks and magnitudes for the final divides.
  always_comb begin
    end_tick = 17'(start_r) + 17'(cnt_r);
    s0_zero  = (s0_r == '0);
    num_bad  = (num_r != '0) && (num_r[NUM_W-1] != s0_r[S0_W-1]);
    m_bad    = (m_r != '0) && (m_r[ACC_W-1] != s0_r[S0_W-1]);
    num_mag  = num_r[NUM_W-1] ? (NUM_W-1)'(-num_r) : num_r[NUM_W-2:0];
    m_mag    = m_r[ACC_W-1] ? ACC_W'(-m_r) : ACC_W'(m_r);
    s0_mag   = s0_r[S0_W-1] ? DVS_W'(-s0_r) : DVS_W'(s0_r);
  end

  // Sequencer and datapath updates.
  always_comb begin
    state_nxt  = state_r;
    floor_nxt  = floor_r;
    sample_nxt = sample_r;
    last_nxt   = last_r;
    en_nxt     = en_r;
    s0_nxt     = s0_r;
    s1_nxt     = s1_r;
    s2_nxt     = s2_r;
    peak_nxt   = peak_r;
    pidx_nxt   = pidx_r;
    cnt_nxt    = cnt_r;
    start_nxt  = start_r;
    prod_nxt   = prod_r;
    num_nxt    = num_r;
    m_nxt      = m_r;
    avg_nxt    = avg_r;
    rms_nxt    = rms_r;
    stat_nxt   = stat_r;
    sqop_nxt   = sqop_r;
    ov_nxt     = ov_r;
    o_qt_nxt   = o_qt_r;
    o_qp_nxt   = o_qp_r;
    o_tp_nxt   = o_tp_r;
    o_ta_nxt   = o_ta_r;
    o_tr_nxt   = o_tr_r;
    o_rs_nxt   = o_rs_r;
    o_re_nxt   = o_re_r;
    o_sz_nxt   = o_sz_r;
    o_st_nxt   = o_st_r;
    ds_cmd     = '0;

    if (cfg_wr_en) begin
      floor_nxt = cfg_wr_data;
    end
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sample_nxt = in_sample;
          last_nxt   = in_last;
          if (in_first) begin
            s0_nxt    = '0;
            s1_nxt    = '0;
            s2_nxt    = '0;
            peak_nxt  = floor_r;
            pidx_nxt  = '0;
            cnt_nxt   = '0;
            start_nxt = in_start_tick;
          end
          state_nxt = S_MUL_A;
        end
      end
      S_MUL_A: begin
        en_nxt   = (cnt_r < CNT_W'(MAX_LEN));
        prod_nxt = mul_full[ACC_W-1:0];
        if ((cnt_r < CNT_W'(MAX_LEN)) && (sample_r > peak_r)) begin
          peak_nxt = sample_r;
          pidx_nxt = cnt_r[IDX_W-1:0];
        end
        state_nxt = S_MUL_B;
      end
      S_MUL_B: begin
        prod_nxt = mul_full[ACC_W-1:0];
        if (en_r) begin
          s0_nxt = s0_r + S0_W'(sample_r);
          s1_nxt = s1_r + prod_r[S1_W-1:0];
        end
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (en_r) begin
          s2_nxt  = s2_r + prod_r[S2_W-1:0];
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        state_nxt = last_r ? S_F_SS : S_IDLE;
      end
      S_F_SS: begin
        prod_nxt  = mul_full[ACC_W-1:0];
        stat_nxt  = ST_OK;
        avg_nxt   = '0;
        rms_nxt   = '0;
        state_nxt = S_F_PS1;
      end
      S_F_PS1: begin
        num_nxt   = prod_r[NUM_W-1:0] + NUM_W'(s1_r);
        prod_nxt  = mul_full[ACC_W-1:0];
        state_nxt = S_F_PS0;
      end
      S_F_PS0: begin
        m_nxt     = ACC_W'(s2_r) - (prod_r <<< 1);
        prod_nxt  = mul_full[ACC_W-1:0];
        state_nxt = S_F_PP;
      end
      S_F_PP: begin
        prod_nxt  = mul_full[ACC_W-1:0];
        state_nxt = S_F_MSUM;
      end
      S_F_MSUM: begin
        m_nxt     = m_r + prod_r;
        state_nxt = S_AVG_GO;
      end
      S_AVG_GO: begin
        if (s0_zero) begin
          stat_nxt  = ST_ZERO_Q;
          state_nxt = S_OUT;
        end else if (num_bad) begin
          state_nxt = S_M_GO;
        end else begin
          ds_cmd.go       = 1'b1;
          ds_cmd.dividend = DVD_W'(num_mag) << FRAC_BITS;
          ds_cmd.divisor  = s0_mag;
          state_nxt       = S_AVG_WAIT;
        end
      end
      S_AVG_WAIT: begin
        if (ds_rsp.done) begin
          avg_nxt = (ds_rsp.value > DVD_W'(AVG_MAX)) ? AVG_MAX
                                                     : ds_rsp.value[AVG_W-1:0];
          state_nxt = S_M_GO;
        end
      end
      S_M_GO: begin
        if (m_bad) begin
          stat_nxt  = ST_NEG_RMS;
          state_nxt = S_OUT;
        end else begin
          ds_cmd.go       = 1'b1;
          ds_cmd.dividend = DVD_W'(m_mag) << (2 * FRAC_BITS);
          ds_cmd.divisor  = s0_mag;
          state_nxt       = S_M_WAIT;
        end
      end
      S_M_WAIT: begin
        if (ds_rsp.done) begin
          sqop_nxt = (ds_rsp.value[DVD_W-1:SQ_W] != '0) ? {SQ_W{1'b1}}
                                                         : ds_rsp.value[SQ_W-1:0];
          state_nxt = S_SQ_GO;
        end
      end
      S_SQ_GO: begin
        ds_cmd.go       = 1'b1;
        ds_cmd.is_sqrt  = 1'b1;
        ds_cmd.dividend = DVD_W'(sqop_r);
        state_nxt       = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (ds_rsp.done) begin
          rms_nxt   = ds_rsp.value[ROOT_W-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Load the result once the output register is free, then open a region.
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          o_qt_nxt  = s0_r;
          o_qp_nxt  = peak_r;
          o_tp_nxt  = 17'(start_r) + 17'(pidx_r);
          o_ta_nxt  = avg_r;
          o_tr_nxt  = rms_r;
          o_rs_nxt  = start_r;
          o_re_nxt  = end_tick;
          o_sz_nxt  = cnt_r;
          o_st_nxt  = stat_r;
          s0_nxt    = '0;
          s1_nxt    = '0;
          s2_nxt    = '0;
          peak_nxt  = floor_r;
          pidx_nxt  = '0;
          cnt_nxt   = '0;
          start_nxt = end_tick[15:0];
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      floor_r <= PEAK_FLOOR_RST;
      s0_r    <= '0;
      s1_r    <= '0;
      s2_r    <= '0;
      peak_r  <= PEAK_FLOOR_RST;
      pidx_r  <= '0;
      cnt_r   <= '0;
      start_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      floor_r <= floor_nxt;
      s0_r    <= s0_nxt;
      s1_r    <= s1_nxt;
      s2_r    <= s2_nxt;
      peak_r  <= peak_nxt;
      pidx_r  <= pidx_nxt;
      cnt_r   <= cnt_nxt;
      start_r <= start_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
    last_r   <= last_nxt;
    en_r     <= en_nxt;
    prod_r   <= prod_nxt;
    num_r    <= num_nxt;
    m_r      <= m_nxt;
    avg_r    <= avg_nxt;
    rms_r    <= rms_nxt;
    stat_r   <= stat_nxt;
    sqop_r   <= sqop_nxt;
    o_qt_r   <= o_qt_nxt;
    o_qp_r   <= o_qp_nxt;
    o_tp_r   <= o_tp_nxt;
    o_ta_r   <= o_ta_nxt;
    o_tr_r   <= o_tr_nxt;
    o_rs_r   <= o_rs_nxt;
    o_re_r   <= o_re_nxt;
    o_sz_r   <= o_sz_nxt;
    o_st_r   <= o_st_nxt;
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = ov_r;
  assign out_q_total      = o_qt_r;
  assign out_q_peak       = o_qp_r;
  assign out_peak_tick    = o_tp_r;
  assign out_mean_tick    = o_ta_r;
  assign out_spread_tick  = o_tr_r;
  assign out_region_start = o_rs_r;
  assign out_region_end   = o_re_r;
  assign out_region_size  = o_sz_r;
  assign out_status       = o_st_r;

endmodule
`default_nettype wire
